// File: rtl/ostp_pkg.sv
package ostp_pkg;

   // Pool size and slot index width; fixed by the 2-bit slot fields
   localparam int SLOTS  = 3;
   localparam int SLOT_W = 2;

   // Widest supported time count
   localparam int MAX_TIME_BITS = 64;

   // Request codes
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_DELETE = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;
   localparam logic [1:0] REQ_TICK   = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_INSERTED = 2'd0;
   localparam logic [1:0] KIND_FULL     = 2'd1;
   localparam logic [1:0] KIND_EXPIRED  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic insert;
      logic scan;
      logic emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
      logic scan_last;
      logic emit_any;
      logic emit_final;
   } stat_type;

endpackage

// File: rtl/ostp_req_if.sv
interface ostp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] duration;
   logic [15:0] user_value;
   logic [1:0]  handler_id;
   logic [1:0]  slot_index;
   logic [47:0] now_time;

   modport source (output valid, req_type, duration, user_value, handler_id, slot_index,
                   now_time, input ready);
   modport sink (input valid, req_type, duration, user_value, handler_id, slot_index,
                 now_time, output ready);
endinterface

// File: rtl/ostp_rsp_if.sv
interface ostp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [1:0]  slot_out;
   logic [15:0] value_out;
   logic [1:0]  handler_out;
   logic        last;

   modport source (output valid, kind, slot_out, value_out, handler_out, last,
                   input ready);
   modport sink (input valid, kind, slot_out, value_out, handler_out, last,
                 output ready);
endinterface

// File: rtl/ostp_ctrl.sv
module ostp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_type,
   output logic               req_ready,
   input  ostp_pkg::stat_type stat,
   output ostp_pkg::cmd_type  cmd
);

   ostp_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ostp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ostp_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_type)
                  ostp_pkg::REQ_INSERT: state_in = ostp_pkg::ST_INSERT;
                  ostp_pkg::REQ_TICK:   state_in = ostp_pkg::ST_SCAN;
                  default:              state_in = ostp_pkg::ST_IDLE;
               endcase
            end
         end
         ostp_pkg::ST_INSERT: begin
            if (stat.out_free) state_in = ostp_pkg::ST_IDLE;
         end
         ostp_pkg::ST_SCAN: begin
            if (stat.scan_last) state_in = ostp_pkg::ST_EMIT;
         end
         ostp_pkg::ST_EMIT: begin
            if (!stat.emit_any) begin
               state_in = ostp_pkg::ST_IDLE;
            end else if (stat.out_free && stat.emit_final) begin
               state_in = ostp_pkg::ST_IDLE;
            end
         end
         default: state_in = ostp_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ostp_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ostp_pkg::ST_INSERT: cmd.insert = stat.out_free;
         ostp_pkg::ST_SCAN:   cmd.scan   = 1'b1;
         ostp_pkg::ST_EMIT:   cmd.emit   = stat.emit_any & stat.out_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: rtl/ostp_datapath.sv
module ostp_datapath #(
   parameter int TIME_BITS = 48
) (
   input  logic               clock,
   input  logic               reset,
   input  ostp_pkg::cmd_type  cmd,
   output ostp_pkg::stat_type stat,
   // request fields
   input  logic [1:0]         req_type,
   input  logic [31:0]        duration,
   input  logic [15:0]        user_value,
   input  logic [1:0]         handler_id,
   input  logic [1:0]         slot_index,
   input  logic [47:0]        now_time,
   // result register
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         kind,
   output logic [1:0]         slot_out,
   output logic [15:0]        value_out,
   output logic [1:0]         handler_out,
   output logic               last
);

   localparam int SLOTS  = ostp_pkg::SLOTS;
   localparam int SLOT_W = ostp_pkg::SLOT_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   // Slot storage
   logic [SLOTS-1:0]     active_ff, active_in;
   logic [TIME_BITS-1:0] deadline_ff [SLOTS];
   logic [15:0]          value_ff    [SLOTS];
   logic [1:0]           handler_ff  [SLOTS];
   logic [TIME_BITS-1:0] cur_time_ff, cur_time_in;

   // Held insert fields
   logic [31:0] dur_ff;
   logic [15:0] val_ff;
   logic [1:0]  hnd_ff;

   // Tick scan state
   logic [SLOT_W-1:0] scan_idx_ff, scan_idx_in;
   logic [SLOTS-1:0]  emit_mask_ff, emit_mask_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        kind_ff, kind_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [15:0]       rval_ff, rval_in;
   logic [1:0]        rhnd_ff, rhnd_in;
   logic              last_ff, last_in;

   logic [ostp_pkg::MAX_TIME_BITS-1:0] now_wide;
   logic [TIME_BITS:0]   sum;
   logic [TIME_BITS-1:0] new_deadline;
   logic                 free_found;
   logic [SLOT_W-1:0]    free_idx;
   logic [SLOT_W-1:0]    emit_idx;
   logic [SLOTS-1:0]     emit_rest;
   logic                 out_free;
   logic                 due;

   assign now_wide = {{(ostp_pkg::MAX_TIME_BITS - 48){1'b0}}, now_time};
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Saturating deadline
   always_comb begin
      sum = {1'b0, cur_time_ff} + {{(TIME_BITS - 31){1'b0}}, dur_ff};
      new_deadline = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
   end

   // Lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   // Lowest pending expiry and what stays after it
   always_comb begin
      emit_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (emit_mask_ff[i]) emit_idx = SLOT_W'(i);
      end
      emit_rest = emit_mask_ff;
      emit_rest[emit_idx] = 1'b0;
   end

   assign due = active_ff[scan_idx_ff] && (deadline_ff[scan_idx_ff] <= cur_time_ff);

   // Control-state next values
   always_comb begin
      active_in    = active_ff;
      cur_time_in  = cur_time_ff;
      scan_idx_in  = scan_idx_ff;
      emit_mask_in = emit_mask_ff;
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      slot_in      = slot_ff;
      rval_in      = rval_ff;
      rhnd_in      = rhnd_ff;
      last_in      = last_ff;

      if (rsp_ready) rsp_valid_in = 1'b0;

      // Delete, clear and time load happen on the transfer itself
      if (cmd.accept) begin
         case (req_type)
            ostp_pkg::REQ_DELETE: begin
               if (slot_index <= LAST_SLOT) active_in[slot_index] = 1'b0;
            end
            ostp_pkg::REQ_CLEAR: active_in = '0;
            ostp_pkg::REQ_TICK: begin
               cur_time_in  = now_wide[TIME_BITS-1:0];
               scan_idx_in  = '0;
               emit_mask_in = '0;
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end

      if (cmd.insert) begin
         rsp_valid_in = 1'b1;
         rval_in      = '0;
         rhnd_in      = '0;
         last_in      = 1'b1;
         if (free_found) begin
            active_in[free_idx] = 1'b1;
            kind_in = ostp_pkg::KIND_INSERTED;
            slot_in = free_idx;
         end else begin
            kind_in = ostp_pkg::KIND_FULL;
            slot_in = '0;
         end
      end

      // One slot compared per cycle
      if (cmd.scan) begin
         if (due) begin
            active_in[scan_idx_ff] = 1'b0;
            if (handler_ff[scan_idx_ff] != 2'd0) emit_mask_in[scan_idx_ff] = 1'b1;
         end
         if (scan_idx_ff != LAST_SLOT) scan_idx_in = scan_idx_ff + 1'b1;
      end

      // One expiry result per cycle while the result register is free, in slot order
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = ostp_pkg::KIND_EXPIRED;
         slot_in      = emit_idx;
         rval_in      = value_ff[emit_idx];
         rhnd_in      = handler_ff[emit_idx];
         last_in      = (emit_rest == '0);
         emit_mask_in = emit_rest;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         cur_time_ff  <= '0;
         scan_idx_ff  <= '0;
         emit_mask_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         cur_time_ff  <= cur_time_in;
         scan_idx_ff  <= scan_idx_in;
         emit_mask_ff <= emit_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      slot_ff <= slot_in;
      rval_ff <= rval_in;
      rhnd_ff <= rhnd_in;
      last_ff <= last_in;
      if (cmd.accept) begin
         dur_ff <= duration;
         val_ff <= user_value;
         hnd_ff <= handler_id;
      end
      if (cmd.insert && free_found) begin
         deadline_ff[free_idx] <= new_deadline;
         value_ff[free_idx]    <= val_ff;
         handler_ff[free_idx]  <= hnd_ff;
      end
   end

   assign stat.out_free   = out_free;
   assign stat.scan_last  = (scan_idx_ff == LAST_SLOT);
   assign stat.emit_any   = (emit_mask_ff != '0);
   assign stat.emit_final = (emit_rest == '0);

   assign rsp_valid   = rsp_valid_ff;
   assign kind        = kind_ff;
   assign slot_out    = slot_ff;
   assign value_out   = rval_ff;
   assign handler_out = rhnd_ff;
   assign last        = last_ff;

endmodule

// File: rtl/one_shot_timer_pool.sv
// Pool of one-shot timers kept against a time base that tick requests load.
// req_chan takes insert, delete, clear-all and tick requests; rsp_chan returns
// insert grants, pool-full refusals and expiry results, each with a last flag.
// One request is worked at a time; req_chan.ready is high only while idle.
// Delete and clear-all finish on the transfer cycle and return no result.
// Insert: the grant or refusal is written to the output register once it is
// free, and the pool is ready again as it is written.
// Tick: the new time is loaded on the transfer, then the slot compare unit
// checks one slot per cycle, then due timers with a handler are reported one
// per cycle in slot order while the receiver does not stall.
// Results sit in a single output register; while the receiver stalls, the
// pending request holds in its state until the register frees.
// Synchronous reset frees every slot, zeroes the current time and drops any
// pending result.
module one_shot_timer_pool #(
   parameter int TIME_BITS = 48
) (
   input logic        clock,
   input logic        reset,
   ostp_req_if.sink   req_chan,
   ostp_rsp_if.source rsp_chan
);

   ostp_pkg::cmd_type  cmd;
   ostp_pkg::stat_type stat;

   ostp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ostp_datapath #(
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_type    (req_chan.req_type),
      .duration    (req_chan.duration),
      .user_value  (req_chan.user_value),
      .handler_id  (req_chan.handler_id),
      .slot_index  (req_chan.slot_index),
      .now_time    (req_chan.now_time),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .kind        (rsp_chan.kind),
      .slot_out    (rsp_chan.slot_out),
      .value_out   (rsp_chan.value_out),
      .handler_out (rsp_chan.handler_out),
      .last        (rsp_chan.last)
   );

endmodule

// File: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT  = 2000;  // cycles with no transfer before giving up
   localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
   localparam int RANDOM_ITEMS = 440;
   localparam int STEADY_ITEMS = 120;   // opening stretch with no idling
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] duration;
      logic [15:0] value;
      logic [1:0]  handler;
      logic [1:0]  slot;
      logic [47:0] tick_at;
   } timer_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  slot;
      logic [15:0] value;
      logic [1:0]  handler;
      logic        last;
   } timer_rsp_type;

   logic clock;
   logic reset;

   ostp_req_if req_bus ();
   ostp_rsp_if rsp_bus ();

   one_shot_timer_pool u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Shadow copy of the timer pool
   logic        pool_active  [ostp_pkg::SLOTS];
   logic [47:0] pool_deadline[ostp_pkg::SLOTS];
   logic [15:0] pool_value   [ostp_pkg::SLOTS];
   logic [1:0]  pool_handler [ostp_pkg::SLOTS];
   logic [47:0] pool_now;

   timer_rsp_type pending_results[$];
   int            mismatch_count;
   int            quiet_cycles;
   int            stall_request;
   bit            gaps_on;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void expect_result(logic [1:0] kind, logic [1:0] slot,
                                         logic [15:0] value, logic [1:0] handler,
                                         logic last);
      timer_rsp_type e;
      e.kind    = kind;
      e.slot    = slot;
      e.value   = value;
      e.handler = handler;
      e.last    = last;
      pending_results.push_back(e);
   endfunction

   // Update the shadow pool for one accepted request and queue its results
   function automatic void pool_apply(timer_req_type r);
      logic [48:0] sum;
      bit          granted;
      int          due_n;
      case (r.op)
         ostp_pkg::REQ_INSERT: begin
            granted = 1'b0;
            for (int i = 0; i < ostp_pkg::SLOTS; i++) begin
               if (!granted && !pool_active[i]) begin
                  sum = {1'b0, pool_now} + {17'b0, r.duration};
                  pool_deadline[i] = sum[48] ? '1 : sum[47:0];
                  pool_value[i]    = r.value;
                  pool_handler[i]  = r.handler;
                  pool_active[i]   = 1'b1;
                  granted          = 1'b1;
                  expect_result(ostp_pkg::KIND_INSERTED, 2'(i), 16'd0, 2'd0, 1'b1);
               end
            end
            if (!granted)
               expect_result(ostp_pkg::KIND_FULL, 2'd0, 16'd0, 2'd0, 1'b1);
         end
         ostp_pkg::REQ_DELETE: begin
            if (r.slot < ostp_pkg::SLOTS)
               pool_active[r.slot] = 1'b0;
         end
         ostp_pkg::REQ_CLEAR: begin
            for (int i = 0; i < ostp_pkg::SLOTS; i++)
               pool_active[i] = 1'b0;
         end
         default: begin
            pool_now = r.tick_at;
            // count the reporting expiries first so the last one gets the flag
            due_n = 0;
            for (int i = 0; i < ostp_pkg::SLOTS; i++)
               if (pool_active[i] && pool_deadline[i] <= pool_now &&
                   pool_handler[i] != 2'd0)
                  due_n++;
            for (int i = 0; i < ostp_pkg::SLOTS; i++) begin
               if (pool_active[i] && pool_deadline[i] <= pool_now) begin
                  pool_active[i] = 1'b0;
                  if (pool_handler[i] != 2'd0) begin
                     due_n--;
                     expect_result(ostp_pkg::KIND_EXPIRED, 2'(i), pool_value[i],
                                   pool_handler[i], due_n == 0);
                  end
               end
            end
         end
      endcase
   endfunction

   function automatic void log_mismatch(string what, timer_rsp_type want,
                                        timer_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $write("%t %s: expected kind=%0d slot=%0d value=%h handler=%0d last=%0b,",
                $realtime, what, want.kind, want.slot, want.value, want.handler,
                want.last);
         $display(" got kind=%0d slot=%0d value=%h handler=%0d last=%0b",
                  got.kind, got.slot, got.value, got.handler, got.last);
      end
   endfunction

   // Request with every field random; callers overwrite what matters
   function automatic timer_req_type random_req();
      timer_req_type r;
      logic [63:0]   wide;
      wide      = {$urandom(), $urandom()};
      r.op      = 2'($urandom_range(3));
      r.duration = $urandom();
      r.value   = 16'($urandom());
      r.handler = 2'($urandom_range(3));
      r.slot    = 2'($urandom_range(3));
      r.tick_at = wide[47:0];
      return r;
   endfunction

   // Offer one request, wait for the transfer, then predict its results
   task automatic send_req(timer_req_type r);
      while (gaps_on && $urandom_range(99) < 28) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= r.op;
      req_bus.duration   <= r.duration;
      req_bus.user_value <= r.value;
      req_bus.handler_id <= r.handler;
      req_bus.slot_index <= r.slot;
      req_bus.now_time   <= r.tick_at;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      pool_apply(r);
   endtask

   task automatic do_insert(logic [31:0] dur, logic [15:0] val, logic [1:0] hnd);
      timer_req_type r = random_req();
      r.op       = ostp_pkg::REQ_INSERT;
      r.duration = dur;
      r.value    = val;
      r.handler  = hnd;
      send_req(r);
   endtask

   task automatic do_delete(logic [1:0] slot);
      timer_req_type r = random_req();
      r.op   = ostp_pkg::REQ_DELETE;
      r.slot = slot;
      send_req(r);
   endtask

   task automatic do_clear();
      timer_req_type r = random_req();
      r.op = ostp_pkg::REQ_CLEAR;
      send_req(r);
   endtask

   task automatic do_tick(logic [47:0] t);
      timer_req_type r = random_req();
      r.op      = ostp_pkg::REQ_TICK;
      r.tick_at = t;
      send_req(r);
   endtask

   // Fill every slot, then one more insert is refused
   task automatic test_fill_and_full();
      do_tick(48'd0);
      do_insert(32'd0, 16'hFFFF, 2'd3);
      do_insert(32'hFFFF_FFFF, 16'h0000, 2'd1);
      do_insert(32'd5, 16'h1234, 2'd0);
      do_insert(32'd7, 16'h0001, 2'd1);
   endtask

   // Silent expiry, slot order and the last flag over three expiries
   task automatic test_expiry_order();
      do_tick(48'd5);
      do_insert(32'd2, 16'h55AA, 2'd2);
      do_insert(32'd3, 16'hAA55, 2'd1);
      do_tick(48'h0000_FFFF_FFFF);
   endtask

   // Out-of-range delete, double delete and clear-all
   task automatic test_delete_clear();
      do_insert(32'd10, 16'h0F0F, 2'd1);
      do_insert(32'd20, 16'hF0F0, 2'd2);
      do_delete(2'd3);
      do_delete(2'd0);
      do_delete(2'd0);
      do_clear();
      do_insert(32'd30, 16'h3C3C, 2'd3);
      do_clear();
   endtask

   // Deadlines that run off the top of the time range saturate
   task automatic test_saturation();
      do_tick(48'hFFFF_FFFF_FFF0);
      do_insert(32'hFFFF_FFFF, 16'h0001, 2'd1);
      do_insert(32'd16, 16'h0002, 2'd2);
      do_insert(32'd15, 16'h0003, 2'd3);
      do_tick(48'hFFFF_FFFF_FFFE);
      do_tick(48'hFFFF_FFFF_FFFF);
   endtask

   // Time moving backwards, and expiry exactly at the deadline
   task automatic test_backward_time();
      do_tick(48'd50);
      do_insert(32'd10, 16'hBEEF, 2'd2);
      do_tick(48'd20);
      do_tick(48'd60);
   endtask

   // Receiver holds off while requests keep coming, so the pool stalls its input
   task automatic test_backpressure();
      stall_request = HOLD_CYCLES;
      do_insert(32'd0, 16'h1111, 2'd1);
      do_insert(32'd0, 16'h2222, 2'd2);
      do_insert(32'd0, 16'h3333, 2'd3);
      do_insert(32'd0, 16'h4444, 2'd1);
      do_tick(pool_now + 48'd1);
      do_insert(32'd1, 16'h5555, 2'd2);
      do_tick(pool_now + 48'd1);
   endtask

   // Mostly forward-moving time with short timers; rare jumps and long timers
   task automatic test_random_mix();
      int          pick;
      logic [31:0] dur;
      logic [47:0] t;
      logic [63:0] wide;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         gaps_on = (n >= STEADY_ITEMS);
         pick = $urandom_range(99);
         if (pick < 40) begin
            dur = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(60);
            do_insert(dur, 16'($urandom()), 2'($urandom_range(3)));
         end else if (pick < 75) begin
            if ($urandom_range(19) == 0) begin
               wide = {$urandom(), $urandom()};
               t = $urandom_range(1) ? wide[47:0] : 48'hFFFF_FFFF_FF00 + $urandom_range(255);
            end else begin
               t = pool_now + $urandom_range(30);
            end
            do_tick(t);
         end else if (pick < 92) begin
            do_delete(2'($urandom_range(3)));
         end else begin
            do_clear();
         end
      end
   endtask

   // Result checker and receiver-side ready
   initial begin
      timer_rsp_type got;
      timer_rsp_type want;
      int            hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.kind    = rsp_bus.kind;
            got.slot    = rsp_bus.slot_out;
            got.value   = rsp_bus.value_out;
            got.handler = rsp_bus.handler_out;
            got.last    = rsp_bus.last;
            if (pending_results.size() == 0) begin
               log_mismatch("unexpected result", '0, got);
            end else begin
               want = pending_results.pop_front();
               if (got.kind !== want.kind || got.slot !== want.slot ||
                   got.value !== want.value || got.handler !== want.handler ||
                   got.last !== want.last)
                  log_mismatch("result mismatch", want, got);
            end
         end
         if (hold_left == 0 && stall_request != 0) begin
            hold_left     = stall_request;
            stall_request = 0;
         end
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= !(gaps_on && $urandom_range(99) < 28);
         end
      end
   end

   // Watchdog: too long without any transfer
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Main sequence
   initial begin
      mismatch_count = 0;
      stall_request  = 0;
      gaps_on        = 1'b1;
      pool_now       = '0;
      for (int i = 0; i < ostp_pkg::SLOTS; i++) begin
         pool_active[i]   = 1'b0;
         pool_deadline[i] = '0;
         pool_value[i]    = '0;
         pool_handler[i]  = '0;
      end
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.req_type   <= ostp_pkg::REQ_INSERT;
      req_bus.duration   <= '0;
      req_bus.user_value <= '0;
      req_bus.handler_id <= '0;
      req_bus.slot_index <= '0;
      req_bus.now_time   <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_and_full();
      test_expiry_order();
      test_delete_clear();
      test_saturation();
      test_backward_time();
      test_random_mix();
      test_backpressure();

      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: sim.f
rtl/ostp_pkg.sv
rtl/ostp_req_if.sv
rtl/ostp_rsp_if.sv
rtl/ostp_ctrl.sv
rtl/ostp_datapath.sv
rtl/one_shot_timer_pool.sv
tb/tb.sv
